>>> sv/rawf_pkg.sv
// Shared types, codes and constants for the register ALU with flags.
package rawf_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned RegCount  = 32;
  localparam int unsigned RegIdxW   = $clog2(RegCount);
  localparam int unsigned ImmW      = 6;

  // Instruction codes carried in the action field.
  localparam logic [4:0] ActAdd64  = 5'd0;
  localparam logic [4:0] ActAdd32  = 5'd1;
  localparam logic [4:0] ActSub64  = 5'd2;
  localparam logic [4:0] ActSub32  = 5'd3;
  localparam logic [4:0] ActAnd64  = 5'd4;
  localparam logic [4:0] ActAnd32  = 5'd5;
  localparam logic [4:0] ActOr64   = 5'd6;
  localparam logic [4:0] ActOr32   = 5'd7;
  localparam logic [4:0] ActXor64  = 5'd8;
  localparam logic [4:0] ActXor32  = 5'd9;
  localparam logic [4:0] ActCmp64  = 5'd10;
  localparam logic [4:0] ActCmp32  = 5'd11;
  localparam logic [4:0] ActTest64 = 5'd12;
  localparam logic [4:0] ActShl64  = 5'd13;
  localparam logic [4:0] ActShr64  = 5'd14;
  localparam logic [4:0] ActSar64  = 5'd15;
  localparam logic [4:0] ActShl32  = 5'd16;
  localparam logic [4:0] ActShr32  = 5'd17;
  localparam logic [4:0] ActSar32  = 5'd18;

  localparam logic [7:0] FlagsReset = 8'h02;

  typedef enum logic [3:0] {
    OpAdd,
    OpSub,
    OpAnd,
    OpOr,
    OpXor,
    OpShl,
    OpShr,
    OpSar,
    OpNop
  } op_e;

  typedef struct packed {
    logic [4:0] action;
    logic       immediate_mode;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } in_t;

  typedef struct packed {
    logic [RegIdxW-1:0]   target_index;
    logic [DataWidth-1:0] target_value;
    logic [7:0]           flag_byte;
    logic                 value_written;
  } out_t;

  // A classified instruction as it waits between the front and the back.
  typedef struct packed {
    op_e                op;
    logic               w32;
    logic               wr;
    logic               imm;
    logic [ImmW-1:0]    imm_val;
    logic [RegIdxW-1:0] rt;
    logic [RegIdxW-1:0] rb;
  } dec_t;

endpackage

>>> sv/register_alu_with_flags.sv
// Top level of the register ALU with flags: front end, issue queue and back end.
//
//  Port group        | Direction | Handshake          | Payload
//  push_i/full_o     | in        | push && !full      | in_i  (action, mode, two bytes)
//  empty_o/pop_i     | out       | pop && !empty      | out_o (index, value, flags, written)
//
// One instruction per cycle is sustained while results are popped. A result
// passes through the issue queue, the register file read stage and the result
// register; the register file forwards a write to a read in the same cycle.
// Reset clears the flags to 0x02 and marks every register as zero at once.
// A stalled result holds the back end; the two-entry queue takes input until full.
module register_alu_with_flags (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  rawf_pkg::in_t  in_i,
  output logic           empty_o,
  input  logic           pop_i,
  output rawf_pkg::out_t out_o
);
  import rawf_pkg::*;

  logic head_valid;
  dec_t head;
  logic deq;

  rawf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_i        (in_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .deq_i       (deq)
  );

  rawf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .deq_o       (deq),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_o       (out_o)
  );

  a_deq_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq |-> head_valid)
    else $error("back end took an item from an empty issue queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !deq) |=> head_valid)
    else $error("accepted item missing from the issue queue");

  a_flag_fixed_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (out_o.flag_byte[1] && !out_o.flag_byte[5] && !out_o.flag_byte[3]))
    else $error("flag byte fixed bits are wrong");

endmodule

>>> sv/rawf_ram.sv
// Generic register file memory: one write port, two registered read ports.
module rawf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> sv/rawf_front.sv
// Front end: decodes incoming instructions into a two-entry issue queue.
module rawf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  rawf_pkg::in_t in_i,
  output logic          head_valid_o,
  output rawf_pkg::dec_t head_o,
  input  logic          deq_i
);
  import rawf_pkg::*;

  dec_t       dec;
  dec_t       q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok;
  logic [RegIdxW-1:0] rb;

  assign rb = {in_i.first_byte[7], in_i.second_byte[7:4]};

  always_comb begin
    dec         = '0;
    dec.rt      = {in_i.first_byte[6], in_i.second_byte[3:0]};
    dec.rb      = rb;
    dec.imm     = in_i.immediate_mode;
    // An immediate of zero stands for thirty-two.
    dec.imm_val = (rb == '0) ? ImmW'(32) : {1'b0, rb};
    dec.wr      = 1'b1;
    dec.w32     = 1'b0;
    dec.op      = OpNop;
    unique case (in_i.action) inside
      ActAdd64, ActAdd32:               dec.op = OpAdd;
      ActSub64, ActSub32:               dec.op = OpSub;
      ActAnd64, ActAnd32:               dec.op = OpAnd;
      ActOr64, ActOr32:                 dec.op = OpOr;
      ActXor64, ActXor32:               dec.op = OpXor;
      ActCmp64, ActCmp32: begin
        dec.op = OpSub;
        dec.wr = 1'b0;
      end
      ActTest64: begin
        dec.op = OpAnd;
        dec.wr = 1'b0;
      end
      ActShl64, ActShl32:               dec.op = OpShl;
      ActShr64, ActShr32:               dec.op = OpShr;
      ActSar64, ActSar32:               dec.op = OpSar;
      default: begin
        dec.op = OpNop;
        dec.wr = 1'b0;
      end
    endcase
    unique case (in_i.action) inside
      ActAdd32, ActSub32, ActAnd32, ActOr32, ActXor32, ActCmp32,
      ActShl32, ActShr32, ActSar32: dec.w32 = 1'b1;
      default:                      dec.w32 = 1'b0;
    endcase
  end

  assign full_o       = (cnt_q == 2'd2);
  assign push_ok      = push_i && !full_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_ok;
    rd_ptr_d = rd_ptr_q ^ deq_i;
    cnt_d    = cnt_q + {1'b0, push_ok} - {1'b0, deq_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

>>> sv/rawf_back.sv
// Back end: register file read, execution, flag update and result register.
module rawf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  rawf_pkg::dec_t head_i,
  output logic           deq_o,
  output logic           empty_o,
  input  logic           pop_i,
  output rawf_pkg::out_t out_o
);
  import rawf_pkg::*;

  logic                 e2_valid_q;
  dec_t                 e2_q;
  logic                 load, fire, we;
  logic [RegCount-1:0]  vld_q;
  logic                 vld_a_q, vld_b_q;
  logic                 fwd_a_q, fwd_b_q;
  logic [DataWidth-1:0] fwd_data_q;
  logic [DataWidth-1:0] ram_a, ram_b;
  logic [DataWidth-1:0] a, breg, b, x, y, r;
  logic [DataWidth:0]   sum, diff, shl_t;
  logic signed [DataWidth+1:0] shr_t;
  logic [DataWidth-1:0] shr_src;
  logic [5:0]           cnt;
  logic                 fill;
  logic                 cf, af, upd;
  logic [7:0]           flags_q, flags_new;
  logic                 out_valid_q;
  out_t                 out_q;

  assign fire  = e2_valid_q && (!out_valid_q || pop_i);
  assign load  = head_valid_i && (!e2_valid_q || fire);
  assign deq_o = load;
  assign we    = fire && e2_q.wr;

  rawf_ram #(
    .Width(DataWidth),
    .Depth(RegCount)
  ) u_regfile (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (e2_q.rt),
    .wdata_i  (r),
    .re_i     (load),
    .raddr_a_i(head_i.rt),
    .raddr_b_i(head_i.rb),
    .rdata_a_o(ram_a),
    .rdata_b_o(ram_b)
  );

  // A register never written since reset reads as zero; a write that retires
  // in the same cycle as the read is forwarded.
  assign a    = fwd_a_q ? fwd_data_q : (vld_a_q ? ram_a : '0);
  assign breg = fwd_b_q ? fwd_data_q : (vld_b_q ? ram_b : '0);
  assign b    = e2_q.imm ? {{(DataWidth-ImmW){1'b0}}, e2_q.imm_val} : breg;
  assign x    = e2_q.w32 ? {32'b0, a[31:0]} : a;
  assign y    = e2_q.w32 ? {32'b0, b[31:0]} : b;

  assign sum  = {1'b0, x} + {1'b0, y};
  assign diff = {1'b0, x} - {1'b0, y};
  assign cnt  = e2_q.w32 ? {1'b0, y[4:0]} : y[5:0];

  assign shl_t   = {1'b0, x} << cnt;
  assign fill    = (e2_q.op == OpSar) && (e2_q.w32 ? x[31] : x[63]);
  assign shr_src = e2_q.w32 ? {{32{fill}}, x[31:0]} : x;
  // The extra low bit catches the last bit shifted out.
  assign shr_t   = $signed({fill, shr_src, 1'b0}) >>> cnt;

  always_comb begin
    logic [DataWidth-1:0] rr;
    rr  = x;
    cf  = 1'b0;
    af  = 1'b0;
    upd = 1'b1;
    case (e2_q.op)
      OpAdd: begin
        rr = sum[DataWidth-1:0];
        cf = e2_q.w32 ? sum[32] : sum[DataWidth];
      end
      OpSub: begin
        rr = diff[DataWidth-1:0];
        cf = diff[DataWidth];
      end
      OpAnd: rr = x & y;
      OpOr:  rr = x | y;
      OpXor: rr = x ^ y;
      OpShl: begin
        rr  = shl_t[DataWidth-1:0];
        cf  = e2_q.w32 ? shl_t[32] : shl_t[DataWidth];
        upd = (cnt != '0);
      end
      OpShr, OpSar: begin
        rr  = shr_t[DataWidth:1];
        cf  = shr_t[0];
        upd = (cnt != '0);
      end
      default: upd = 1'b0;
    endcase
    if (e2_q.w32) begin
      rr = {32'b0, rr[31:0]};
    end
    if (e2_q.op == OpAdd || e2_q.op == OpSub) begin
      af = x[4] ^ y[4] ^ rr[4];
    end
    r = rr;
  end

  always_comb begin
    flags_new = flags_q;
    if (upd) begin
      flags_new = {e2_q.w32 ? r[31] : r[DataWidth-1], (r == '0), 1'b0, af,
                   1'b0, ~^r[7:0], 1'b1, cf};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      flags_q     <= FlagsReset;
    end else begin
      if (load) begin
        e2_valid_q <= 1'b1;
      end else if (fire) begin
        e2_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_new;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (we) begin
        vld_q[e2_q.rt] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      e2_q       <= head_i;
      vld_a_q    <= vld_q[head_i.rt];
      vld_b_q    <= vld_q[head_i.rb];
      fwd_a_q    <= we && (e2_q.rt == head_i.rt);
      fwd_b_q    <= we && (e2_q.rt == head_i.rb);
      fwd_data_q <= r;
    end
    if (fire) begin
      out_q.target_index  <= e2_q.rt;
      out_q.target_value  <= e2_q.wr ? r : a;
      out_q.flag_byte     <= flags_new;
      out_q.value_written <= e2_q.wr;
    end
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

endmodule
